### src/fjd_pkg.sv
// Shared constants, types and codes for the Jacobi diagonal accumulator.
`default_nettype none

package fjd_pkg;

  localparam int NODE_COUNT_DEF = 4096;
  localparam int ACC_BITS_DEF   = 48;

  localparam int JAC_WORDS = 10;
  localparam int JAC_IDX_W = 4;
  localparam int AXES      = 3;
  localparam int FRAC      = 16;
  localparam int WORD_W    = 32;
  localparam int COEF_W    = 31;
  localparam int NODE_W    = 12;
  localparam int CFG_IDX_W = 2;

  // multiplier and accumulator widths
  localparam int MUL_W  = 33;
  localparam int PROD_W = 66;
  localparam int SUM_W  = 98;
  localparam int Q_W    = 47;
  localparam int QS_W   = 48;
  localparam int T1_W   = 62;
  localparam int QUAD_W = 63;

  // node modulo by reciprocal
  localparam int MOD_SHIFT = 24;
  localparam int MOD_W     = 40;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_NODE  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_C_NORMAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_C_SHEAR  = 2'd1;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic sat;
  } calc_stat_t;

endpackage

`default_nettype wire

### src/fjd_ram.sv
// Single-write, single-read synchronous memory with registered read data.
`default_nettype none

module fjd_ram #(
  parameter int DEPTH = fjd_pkg::NODE_COUNT_DEF,
  parameter int WIDTH = 3 * fjd_pkg::ACC_BITS_DEF + 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/fjd_calc.sv
// Sequenced fixed-point arithmetic of one node contribution on a shared multiplier.
`default_nettype none

module fjd_calc #(
  parameter int ACC_BITS = fjd_pkg::ACC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [fjd_pkg::WORD_W-1:0]    grad_x,
  input  wire logic [fjd_pkg::WORD_W-1:0]    grad_y,
  input  wire logic [fjd_pkg::WORD_W-1:0]    grad_z,
  input  wire logic [fjd_pkg::WORD_W-1:0]    weight,
  input  var  fjd_pkg::word_t                jac [fjd_pkg::JAC_WORDS],
  input  wire logic [fjd_pkg::COEF_W-1:0]    c_normal,
  input  wire logic [fjd_pkg::COEF_W-1:0]    c_shear,
  output logic signed [ACC_BITS-1:0]         contrib [fjd_pkg::AXES],
  output fjd_pkg::calc_stat_t                stat
);

  localparam int SUM_W  = fjd_pkg::SUM_W;
  localparam int FRAC   = fjd_pkg::FRAC;
  localparam int WORD_W = fjd_pkg::WORD_W;
  localparam int MUL_W  = fjd_pkg::MUL_W;
  localparam int Q_W    = fjd_pkg::Q_W;
  localparam int QS_W   = fjd_pkg::QS_W;
  localparam int T1_W   = fjd_pkg::T1_W;
  localparam int QUAD_W = fjd_pkg::QUAD_W;
  localparam int M_W    = SUM_W - FRAC;
  localparam logic [M_W-1:0] AMAX_EXT = {{(M_W-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
  localparam logic [ACC_BITS-1:0] AMAX = {1'b0, {(ACC_BITS-1){1'b1}}};

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_G    = 5'b00010,
    PH_W    = 5'b00100,
    PH_Q    = 5'b01000,
    PH_AX   = 5'b10000
  } ph_t;

  ph_t                        ph_r;
  logic                       half_r;   // 0: multiply, 1: accumulate
  logic [1:0]                 a_r;
  logic [2:0]                 k_r;
  logic                       done_r;
  logic                       sat_r;

  fjd_pkg::word_t             s_r [fjd_pkg::AXES];
  fjd_pkg::word_t             wt_r;
  fjd_pkg::word_t             g_r [fjd_pkg::AXES];
  fjd_pkg::word_t             w_r;
  logic [Q_W-1:0]             q_r [fjd_pkg::AXES];
  logic [QS_W-1:0]            qsum_r;
  logic [T1_W-1:0]            t1_r;
  logic [QUAD_W-1:0]          quad_r;
  logic signed [fjd_pkg::PROD_W-1:0] p_r;
  logic signed [SUM_W-1:0]    acc_r;
  logic signed [ACC_BITS-1:0] contrib_r [fjd_pkg::AXES];

  logic signed [MUL_W-1:0]    a_op;
  logic signed [MUL_W-1:0]    b_op;
  logic                       sh32;
  logic                       clr;
  logic [fjd_pkg::JAC_IDX_W-1:0] jidx;
  logic [Q_W-1:0]             qa;
  logic [QS_W-1:0]            qo;
  logic [WORD_W-1:0]          wmag;
  logic [SUM_W-1:0]           addend;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    sh_v;
  logic                       g_ovf;
  fjd_pkg::word_t             g_val;
  logic [M_W-1:0]             m;
  logic                       m_ovf;
  logic [ACC_BITS-1:0]        mag;

  // operand selection: J^T s, det*weight, squares, then per axis the
  // coefficient products and the scale by |w|, wide factors in two halves
  always_comb begin
    a_op = '0;
    b_op = '0;
    sh32 = 1'b0;
    clr  = 1'b0;
    jidx = fjd_pkg::JAC_IDX_W'({k_r[1:0], 1'b0}) + fjd_pkg::JAC_IDX_W'(k_r[1:0])
         + fjd_pkg::JAC_IDX_W'(a_r);
    qa   = q_r[a_r];
    qo   = qsum_r - QS_W'(qa);
    wmag = w_r[WORD_W-1] ? WORD_W'(-w_r) : WORD_W'(w_r);
    case (ph_r)
      PH_G: begin
        a_op = {jac[jidx][WORD_W-1], jac[jidx]};
        b_op = {s_r[k_r[1:0]][WORD_W-1], s_r[k_r[1:0]]};
        clr  = (k_r == 3'd0);
      end
      PH_W: begin
        a_op = {jac[fjd_pkg::JAC_WORDS-1][WORD_W-1], jac[fjd_pkg::JAC_WORDS-1]};
        b_op = {wt_r[WORD_W-1], wt_r};
        clr  = 1'b1;
      end
      PH_Q: begin
        a_op = {g_r[a_r][WORD_W-1], g_r[a_r]};
        b_op = {g_r[a_r][WORD_W-1], g_r[a_r]};
        clr  = 1'b1;
      end
      PH_AX: begin
        case (k_r)
          3'd0: begin
            a_op = {2'b00, c_normal};
            b_op = {1'b0, qa[WORD_W-1:0]};
            clr  = 1'b1;
          end
          3'd1: begin
            a_op = {2'b00, c_normal};
            b_op = {{(MUL_W-Q_W+WORD_W){1'b0}}, qa[Q_W-1:WORD_W]};
            sh32 = 1'b1;
          end
          3'd2: begin
            a_op = {2'b00, c_shear};
            b_op = {1'b0, qo[WORD_W-1:0]};
            clr  = 1'b1;
          end
          3'd3: begin
            a_op = {2'b00, c_shear};
            b_op = {{(MUL_W-QS_W+WORD_W){1'b0}}, qo[QS_W-1:WORD_W]};
            sh32 = 1'b1;
          end
          3'd4: begin
            a_op = {1'b0, quad_r[WORD_W-1:0]};
            b_op = {1'b0, wmag};
            clr  = 1'b1;
          end
          3'd5: begin
            a_op = {{(MUL_W-QUAD_W+WORD_W){1'b0}}, quad_r[QUAD_W-1:WORD_W]};
            b_op = {1'b0, wmag};
            sh32 = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    addend = sh32 ? {p_r, {WORD_W{1'b0}}} : {{WORD_W{p_r[fjd_pkg::PROD_W-1]}}, p_r};
    sum    = (clr ? '0 : acc_r) + $signed(addend);
    sh_v   = sum >>> FRAC;
    g_ovf  = !((&sh_v[SUM_W-1:WORD_W-1]) || !(|sh_v[SUM_W-1:WORD_W-1]));
    if (!g_ovf) begin
      g_val = sh_v[WORD_W-1:0];
    end else if (sh_v[SUM_W-1]) begin
      g_val = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      g_val = {1'b0, {(WORD_W-1){1'b1}}};
    end
    m     = sum[SUM_W-1:FRAC];
    m_ovf = (m > AMAX_EXT);
    mag   = m_ovf ? AMAX : m[ACC_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      half_r <= 1'b0;
      a_r    <= '0;
      k_r    <= '0;
      done_r <= 1'b0;
      sat_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ph_r == PH_IDLE) begin
        if (start) begin
          ph_r   <= PH_G;
          half_r <= 1'b0;
          a_r    <= '0;
          k_r    <= '0;
          sat_r  <= 1'b0;
        end
      end else begin
        half_r <= ~half_r;
        if (half_r) begin
          case (ph_r)
            PH_G: begin
              if (k_r == 3'd2) begin
                k_r   <= '0;
                sat_r <= sat_r | g_ovf;
                if (a_r == 2'd2) begin
                  a_r  <= '0;
                  ph_r <= PH_W;
                end else begin
                  a_r <= a_r + 2'd1;
                end
              end else begin
                k_r <= k_r + 3'd1;
              end
            end
            PH_W: begin
              sat_r <= sat_r | g_ovf;
              ph_r  <= PH_Q;
            end
            PH_Q: begin
              if (a_r == 2'd2) begin
                a_r  <= '0;
                k_r  <= '0;
                ph_r <= PH_AX;
              end else begin
                a_r <= a_r + 2'd1;
              end
            end
            PH_AX: begin
              if (k_r == 3'd5) begin
                k_r   <= '0;
                sat_r <= sat_r | m_ovf;
                if (a_r == 2'd2) begin
                  a_r    <= '0;
                  ph_r   <= PH_IDLE;
                  done_r <= 1'b1;
                end else begin
                  a_r <= a_r + 2'd1;
                end
              end else begin
                k_r <= k_r + 3'd1;
              end
            end
            default: ph_r <= PH_IDLE;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ph_r == PH_IDLE && start) begin
      s_r[0] <= grad_x;
      s_r[1] <= grad_y;
      s_r[2] <= grad_z;
      wt_r   <= weight;
    end
    if (ph_r != PH_IDLE && !half_r) begin
      p_r <= a_op * b_op;
    end
    if (ph_r != PH_IDLE && half_r) begin
      acc_r <= sum;
      case (ph_r)
        PH_G: begin
          if (k_r == 3'd2) begin
            g_r[a_r] <= g_val;
          end
        end
        PH_W: w_r <= g_val;
        PH_Q: begin
          q_r[a_r] <= sum[FRAC +: Q_W];
          qsum_r   <= ((a_r == 2'd0) ? '0 : qsum_r) + QS_W'(sum[FRAC +: Q_W]);
        end
        PH_AX: begin
          case (k_r)
            3'd1: t1_r <= sum[FRAC +: T1_W];
            3'd3: quad_r <= QUAD_W'(t1_r) + sum[FRAC +: QUAD_W];
            3'd5: contrib_r[a_r] <= w_r[WORD_W-1] ? $signed(-mag) : $signed(mag);
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign contrib = contrib_r;
  assign stat    = '{busy: (ph_r != PH_IDLE), done: done_r, sat: sat_r};

endmodule

`default_nettype wire

### src/fem_jacobi_diagonal_accumulate.sv
// Top level: item control, Jacobian words, node store read-modify-write and result register.
// Sequence: a load is written while idle; a clear forms the node address, then writes a zero row;
//   a read forms the address, reads the row and waits until the result register is free; a node
//   contribution runs 31 products on one shared 33x33 multiplier, then one write-back.
// Throughput: one item at a time; the next item is taken once the current one is finished.
// Reset: synchronous active-low; afterwards the node store is swept to zero, one node per
//   cycle over all NODE_COUNT nodes, and no item is taken until the sweep ends.
`default_nettype none

module fem_jacobi_diagonal_accumulate #(
  parameter int NODE_COUNT = fjd_pkg::NODE_COUNT_DEF,
  parameter int ACC_BITS   = fjd_pkg::ACC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // item input
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       in_opcode,
  input  wire logic [3:0]                       in_jac_slot,
  input  wire logic signed [fjd_pkg::WORD_W-1:0] in_jac_value,
  input  wire logic [fjd_pkg::NODE_W-1:0]       in_node_index,
  input  wire logic signed [fjd_pkg::WORD_W-1:0] in_grad_x,
  input  wire logic signed [fjd_pkg::WORD_W-1:0] in_grad_y,
  input  wire logic signed [fjd_pkg::WORD_W-1:0] in_grad_z,
  input  wire logic signed [fjd_pkg::WORD_W-1:0] in_weight,
  // result output
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [fjd_pkg::NODE_W-1:0]            out_node,
  output logic signed [ACC_BITS-1:0]            out_diag_x,
  output logic signed [ACC_BITS-1:0]            out_diag_y,
  output logic signed [ACC_BITS-1:0]            out_diag_z,
  output logic                                  out_saturated,
  // configuration writes
  input  wire logic                             cfg_we,
  input  wire logic [fjd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fjd_pkg::COEF_W-1:0]       cfg_data
);

  localparam int ADDR_W = $clog2(NODE_COUNT);
  localparam int ROW_W  = 3 * ACC_BITS + 1;   // {sat, z, y, x}
  localparam int MOD_W  = fjd_pkg::MOD_W;
  localparam int NODE_W = fjd_pkg::NODE_W;
  // quotient estimate node / NODE_COUNT = (node * RECIP) >> MOD_SHIFT, exact for 12-bit nodes
  localparam longint RECIP = ((64'd1 << fjd_pkg::MOD_SHIFT) + NODE_COUNT - 1) / NODE_COUNT;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NODE_COUNT - 1);
  localparam logic signed [ACC_BITS-1:0] AMAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] AMIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  typedef enum logic [6:0] {
    ST_CLR  = 7'b0000001,   // post-reset sweep of the node store
    ST_IDLE = 7'b0000010,
    ST_ADR1 = 7'b0000100,   // quotient estimate
    ST_ADR2 = 7'b0001000,   // remainder, memory access issued
    ST_RD   = 7'b0010000,   // row in hand, waiting for the result register
    ST_CALC = 7'b0100000,   // arithmetic running
    ST_WB   = 7'b1000000    // saturating add and write back
  } state_t;

  state_t                    state_r;
  logic [ADDR_W-1:0]         clr_cnt_r;
  fjd_pkg::opcode_t          op_r;
  logic [NODE_W-1:0]         node_r;
  logic [NODE_W-1:0]         quo_r;
  logic [ADDR_W-1:0]         addr_r;

  fjd_pkg::word_t            jac_r [fjd_pkg::JAC_WORDS];
  logic [fjd_pkg::COEF_W-1:0] cn_r;
  logic [fjd_pkg::COEF_W-1:0] cs_r;

  logic                      out_valid_r;
  logic [NODE_W-1:0]         out_node_r;
  logic signed [ACC_BITS-1:0] out_diag_r [fjd_pkg::AXES];
  logic                      out_sat_r;

  logic                      in_acc;
  logic                      calc_start;
  fjd_pkg::calc_stat_t       calc_stat;
  logic signed [ACC_BITS-1:0] contrib [fjd_pkg::AXES];

  logic [MOD_W-1:0]          mod_prod;
  logic [MOD_W-1:0]          rem_full;
  logic [MOD_W-1:0]          rem_fix;
  logic [ADDR_W-1:0]         addr_nxt;

  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr;
  logic [ROW_W-1:0]          mem_wdata;
  logic                      mem_re;
  logic [ROW_W-1:0]          mem_rdata;

  logic signed [ACC_BITS-1:0] new_acc [fjd_pkg::AXES];
  logic [fjd_pkg::AXES-1:0]  clamp;
  logic [ACC_BITS:0]         wide_sum [fjd_pkg::AXES];
  logic                      out_load;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign calc_start = in_acc && (in_opcode == fjd_pkg::OP_NODE);
  assign out_load   = (state_r == ST_RD) && (!out_valid_r || out_ready);

  // node modulo NODE_COUNT: multiply by reciprocal, then one correcting subtract
  always_comb begin
    mod_prod = MOD_W'(node_r) * MOD_W'(RECIP);
    rem_full = MOD_W'(node_r) - MOD_W'(quo_r) * MOD_W'(NODE_COUNT);
    rem_fix  = (rem_full >= MOD_W'(NODE_COUNT)) ? rem_full - MOD_W'(NODE_COUNT) : rem_full;
    addr_nxt = ADDR_W'(rem_fix);
  end

  // saturating accumulation of the three contributions
  always_comb begin
    for (int a = 0; a < fjd_pkg::AXES; a++) begin
      wide_sum[a] = {mem_rdata[a*ACC_BITS + ACC_BITS - 1], mem_rdata[a*ACC_BITS +: ACC_BITS]}
                  + {contrib[a][ACC_BITS-1], contrib[a]};
      clamp[a]    = (wide_sum[a][ACC_BITS] != wide_sum[a][ACC_BITS-1]);
      if (!clamp[a]) begin
        new_acc[a] = wide_sum[a][ACC_BITS-1:0];
      end else if (wide_sum[a][ACC_BITS]) begin
        new_acc[a] = AMIN;
      end else begin
        new_acc[a] = AMAX;
      end
    end
  end

  // single memory port pair: sweep, clear, read and write-back never overlap
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = '0;
    mem_re    = 1'b0;
    case (state_r)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
      end
      ST_ADR2: begin
        if (op_r == fjd_pkg::OP_CLEAR) begin
          mem_we    = 1'b1;
          mem_waddr = addr_nxt;
        end else begin
          mem_re = 1'b1;
        end
      end
      ST_WB: begin
        mem_we    = 1'b1;
        mem_wdata = {mem_rdata[ROW_W-1] | calc_stat.sat | (|clamp),
                     new_acc[2], new_acc[1], new_acc[0]};
      end
      default: ;
    endcase
  end

  fjd_ram #(
    .DEPTH (NODE_COUNT),
    .WIDTH (ROW_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr_nxt),
    .rdata (mem_rdata)
  );

  fjd_calc #(
    .ACC_BITS (ACC_BITS)
  ) u_calc (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (calc_start),
    .grad_x   (in_grad_x),
    .grad_y   (in_grad_y),
    .grad_z   (in_grad_z),
    .weight   (in_weight),
    .jac      (jac_r),
    .c_normal (cn_r),
    .c_shear  (cs_r),
    .contrib  (contrib),
    .stat     (calc_stat)
  );

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      cn_r        <= '0;
      cs_r        <= '0;
      for (int i = 0; i < fjd_pkg::JAC_WORDS; i++) begin
        jac_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == fjd_pkg::CFG_C_NORMAL) begin
          cn_r <= cfg_data;
        end else if (cfg_index == fjd_pkg::CFG_C_SHEAR) begin
          cs_r <= cfg_data;
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == LAST_ADDR) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            if (in_opcode == fjd_pkg::OP_LOAD) begin
              if (in_jac_slot < 4'(fjd_pkg::JAC_WORDS)) begin
                jac_r[in_jac_slot] <= in_jac_value;
              end
            end else begin
              state_r <= ST_ADR1;
            end
          end
        end
        ST_ADR1: state_r <= ST_ADR2;
        ST_ADR2: begin
          case (op_r)
            fjd_pkg::OP_READ: state_r <= ST_RD;
            fjd_pkg::OP_NODE: state_r <= ST_CALC;
            default:          state_r <= ST_IDLE;
          endcase
        end
        ST_RD: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        ST_CALC: begin
          if (calc_stat.done) begin
            state_r <= ST_WB;
          end
        end
        ST_WB:   state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= fjd_pkg::opcode_t'(in_opcode);
      node_r <= in_node_index;
    end
    if (state_r == ST_ADR1) begin
      quo_r <= mod_prod[fjd_pkg::MOD_SHIFT +: NODE_W];
    end
    if (state_r == ST_ADR2) begin
      addr_r <= addr_nxt;
    end
    if (out_load) begin
      out_node_r <= node_r;
      for (int a = 0; a < fjd_pkg::AXES; a++) begin
        out_diag_r[a] <= mem_rdata[a*ACC_BITS +: ACC_BITS];
      end
      out_sat_r <= mem_rdata[ROW_W-1];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_node      = out_node_r;
  assign out_diag_x    = out_diag_r[0];
  assign out_diag_y    = out_diag_r[1];
  assign out_diag_z    = out_diag_r[2];
  assign out_saturated = out_sat_r;

  // write-back only follows a finished calculation
  a_wb_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB) |-> $past(calc_stat.done))
    else $error("write-back without finished calculation");

  // arithmetic unit is quiet whenever the block takes items
  a_idle_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !calc_stat.busy)
    else $error("arithmetic busy while idle");

  // one memory access per cycle
  a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("read and write in the same cycle");

  // a read row moves into the result register and frees the block
  a_rd_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid && state_r == ST_IDLE))
    else $error("read result not presented");

endmodule

`default_nettype wire
